// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands shared by the text console writer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define TCW_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define TCW_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hdl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// screen geometry, field widths, codes and shared types of the text console
// ----------------------------------------------------------------------------
package tcw_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int CELL_W     = $clog2(CELL_COUNT);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int COL_W      = $clog2(COLUMNS);

   // request and response field widths
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 8;
   localparam int INDEX_W = 11;
   localparam int POS_W   = 11;
   localparam int CELL_VW = COLOR_W + CHAR_W;

   // commands
   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // character and color codes
   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_FILL
   } tcw_state_type;

   // put step handed to the cursor tracker
   typedef struct packed {
      logic put;
      logic newline;
   } tcw_step_type;

   // cursor tracker status
   typedef struct packed {
      logic [CELL_W-1:0] lin;
      logic [CELL_W-1:0] next_lin;
      logic [CELL_W-1:0] put_addr;
      logic [CELL_W-1:0] top_base;
      logic              scroll;
   } tcw_cursor_type;

   // logical linear cell to physical ram address, rows rotate by top_base
   function automatic logic [CELL_W-1:0] tcw_phys_addr(input logic [CELL_W-1:0] lin,
                                                      input logic [CELL_W-1:0] base);
      logic [CELL_W:0] sum;
      sum = {1'b0, lin} + {1'b0, base};
      if (sum >= (CELL_W+1)'(CELL_COUNT)) begin
         sum = sum - (CELL_W+1)'(CELL_COUNT);
      end
      return sum[CELL_W-1:0];
   endfunction

endpackage

// ===== hdl/text_console_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_unit
// text-mode console: screen ram with rotating rows, cursor and scroll fill
// ----------------------------------------------------------------------------
//
//  channel   ports                                         direction
//  -------   -------------------------------------------   ---------
//  request   req_valid/ready, command, char_code, cell_index   in
//  response  rsp_valid/ready, cursor_position, cell_value,
//            scrolled                                         out
//  csr       csr_write_enable, csr_write_data (text color)    in
//
//  a read, unlike a put, passes through ST_READ for the registered ram read
//  a put that scrolls adds a blank fill (ST_FILL) of the COLUMNS cells of the new bottom
//  row; scrolling itself only rotates the top-row base, no cells are copied
//  after reset a clearing pass blanks every cell before any request
//  req_ready is low during the clearing pass, a read, a fill, and while a
//  response is held that is not being taken in the same cycle
//
module text_console_writer_unit import tcw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic [CHAR_W-1:0]  req_char_code,
   input  logic [INDEX_W-1:0] req_cell_index,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [POS_W-1:0]   rsp_cursor_position,
   output logic [CELL_VW-1:0] rsp_cell_value,
   output logic               rsp_scrolled,
   // configuration
   input  logic               csr_write_enable,
   input  logic [COLOR_W-1:0] csr_write_data
);

`include "assert_macros.svh"

   tcw_state_type     state_ff, state_in;
   logic [CELL_W-1:0] sweep_ff, sweep_in;

   logic [COLOR_W-1:0] text_color_ff;
   logic [COLOR_W-1:0] fill_color_ff;
   logic [CELL_W-1:0]  fill_base_ff;
   logic               oor_ff;

   logic               rsp_valid_ff;
   logic [POS_W-1:0]   rsp_pos_ff;
   logic [CELL_VW-1:0] rsp_cell_ff;
   logic               rsp_scrolled_ff;

   logic accept;
   logic put_acc;
   logic read_acc;
   logic read_oor;

   tcw_step_type   step;
   tcw_cursor_type cur;

   // ram ports
   logic               ram_we;
   logic [CELL_W-1:0]  ram_waddr;
   logic [CELL_VW-1:0] ram_wdata;
   logic               ram_re;
   logic [CELL_W-1:0]  ram_raddr;
   logic [CELL_VW-1:0] ram_rdata;

   // one request at a time, only when the response slot is free or draining
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign put_acc   = accept && (req_command == CMD_PUT);
   assign read_acc  = accept && (req_command == CMD_READ);
   assign read_oor  = (req_cell_index >= INDEX_W'(CELL_COUNT));

   assign step.put     = put_acc;
   assign step.newline = (req_char_code == NEWLINE_CODE);

   tcw_cursor u_cursor (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .status (cur)
   );

   tcw_screen_ram #(
      .DEPTH (CELL_COUNT),
      .WIDTH (CELL_VW)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // read port: logical index rotated onto the physical rows
   assign ram_re    = read_acc;
   assign ram_raddr = tcw_phys_addr(CELL_W'(req_cell_index), cur.top_base);

   // sequencer: clearing pass, idle, read wait, scroll fill
   always_comb begin
      state_in  = state_ff;
      sweep_in  = sweep_ff;
      ram_we    = 1'b0;
      ram_waddr = cur.put_addr;
      ram_wdata = {text_color_ff, req_char_code};
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = {RESET_COLOR, BLANK_CODE};
            sweep_in  = sweep_ff + CELL_W'(1);
            if (sweep_ff == CELL_W'(CELL_COUNT - 1)) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // newline stores nothing, any other byte lands at the cursor
            ram_we = put_acc && !step.newline;
            if (read_acc) begin
               state_in = ST_READ;
            end else if (put_acc && cur.scroll) begin
               state_in = ST_FILL;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_FILL: begin
            // old top row becomes the bottom row, blank it in the latched color
            ram_we    = 1'b1;
            ram_waddr = fill_base_ff + sweep_ff;
            ram_wdata = {fill_color_ff, BLANK_CODE};
            sweep_in  = sweep_ff + CELL_W'(1);
            if (sweep_ff == CELL_W'(COLUMNS - 1)) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

   // text color register
   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= RESET_COLOR;
      end else if (csr_write_enable) begin
         text_color_ff <= csr_write_data;
      end
   end

   // fill color and row base captured when the scroll starts, so a color
   // write during the fill does not leak into it
   always_ff @(posedge clock) begin
      if (put_acc && cur.scroll) begin
         fill_color_ff <= text_color_ff;
         fill_base_ff  <= cur.top_base;
      end
      if (read_acc) begin
         oor_ff <= read_oor;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (put_acc || (state_ff == ST_READ)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (put_acc) begin
         rsp_pos_ff      <= POS_W'(cur.next_lin);
         rsp_cell_ff     <= '0;
         rsp_scrolled_ff <= cur.scroll;
      end else if (state_ff == ST_READ) begin
         rsp_pos_ff      <= POS_W'(cur.lin);
         rsp_cell_ff     <= oor_ff ? '0 : ram_rdata;
         rsp_scrolled_ff <= 1'b0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_value      = rsp_cell_ff;
   assign rsp_scrolled        = rsp_scrolled_ff;

   // a scrolling put always starts the fill sweep
   `TCW_ASSERT_NEXT(a_scroll_fill, put_acc && cur.scroll, state_ff == ST_FILL, "fill missing")
   // a read passes through ST_READ before its response is valid
   `TCW_ASSERT_NEXT(a_read_rsp, read_acc, (state_ff == ST_READ) ##1 rsp_valid_ff, "read lost")
   // the fill sweep never leaves its row
   `TCW_ASSERT_NOW(a_fill_bound, state_ff == ST_FILL, sweep_ff < CELL_W'(COLUMNS), "fill overrun")
   // reported cursor stays on the screen
   `TCW_ASSERT_NOW(a_cursor_range, rsp_valid_ff, rsp_pos_ff < POS_W'(CELL_COUNT), "cursor off screen")

endmodule

// ===== hdl/tcw_screen_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_screen_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
   parameter int DEPTH = 2000,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/tcw_cursor.sv =====
// ----------------------------------------------------------------------------
// tcw_cursor
// cursor row, column and linear position plus the rotating top-row base
// ----------------------------------------------------------------------------
module tcw_cursor import tcw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  tcw_step_type   step,
   output tcw_cursor_type status
);

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CELL_W-1:0] lin_ff, lin_in;
   logic [CELL_W-1:0] base_ff, base_in;
   logic [CELL_W:0]   base_sum;
   logic              wrap;
   logic              scroll;

   always_comb begin
      wrap     = step.newline || (col_ff == COL_W'(COLUMNS - 1));
      scroll   = wrap && (row_ff == ROW_W'(ROWS - 1));
      base_sum = {1'b0, base_ff} + (CELL_W+1)'(COLUMNS);
      if (base_sum >= (CELL_W+1)'(CELL_COUNT)) begin
         base_sum = base_sum - (CELL_W+1)'(CELL_COUNT);
      end

      row_in  = row_ff;
      col_in  = col_ff;
      lin_in  = lin_ff;
      base_in = base_ff;
      priority if (scroll) begin
         // stay on the last row, the top row rotates to the bottom
         col_in  = '0;
         lin_in  = CELL_W'((ROWS - 1) * COLUMNS);
         base_in = base_sum[CELL_W-1:0];
      end else if (wrap) begin
         col_in = '0;
         row_in = row_ff + ROW_W'(1);
         lin_in = lin_ff - CELL_W'(col_ff) + CELL_W'(COLUMNS);
      end else begin
         col_in = col_ff + COL_W'(1);
         lin_in = lin_ff + CELL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         lin_ff  <= '0;
         base_ff <= '0;
      end else if (step.put) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         lin_ff  <= lin_in;
         base_ff <= base_in;
      end
   end

   assign status.lin      = lin_ff;
   assign status.next_lin = lin_in;
   assign status.put_addr = tcw_phys_addr(lin_ff, base_ff);
   assign status.top_base = base_ff;
   assign status.scroll   = scroll;

endmodule
